// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types for the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    // Default sizes
    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;       // capture the request
        logic    do_insert;  // shift cells open and write the new entry
        logic    do_remove;  // pop cell 0 and shift down
        logic    emit;       // register a result
        status_t result;     // status code of the result
    } spq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic op_remove;     // captured request is a remove
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

`default_nettype wire

// ----- design/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: captures a request, then decides and issues the
// queue operation and its result status.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire spq_stat_t dp_stat,
    output spq_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.result    = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.emit = 1'b1;
                if (dp_stat.op_remove)
                begin
                    if (dp_stat.empty)
                        cmd.result = STAT_EMPTY;
                    else
                        cmd.do_remove = 1'b1;
                end
                else
                begin
                    if (dp_stat.full)
                        cmd.result = STAT_FULL;
                    else
                        cmd.do_insert = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Row of sorted key/payload cells with per-cell compare, the occupancy
// counter and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CNT_W       = $clog2(DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire spq_cmd_t                cmd,
    output spq_stat_t                    dp_stat,
    input  wire logic                    opcode,
    input  wire logic [KEY_BITS-1:0]     entry_key,
    input  wire logic [PAYLOAD_BITS-1:0] entry_payload,
    output logic                         done,
    output logic                         removed_valid,
    output logic [KEY_BITS-1:0]          removed_key,
    output logic [PAYLOAD_BITS-1:0]      removed_payload,
    output logic [CNT_W-1:0]             stored_count,
    output logic                         is_empty,
    output logic [1:0]                   status
);

    // Captured request
    logic                    op_reg;
    logic [KEY_BITS-1:0]     new_key_reg;
    logic [PAYLOAD_BITS-1:0] new_pay_reg;

    // Cells, ascending key from cell 0
    logic [KEY_BITS-1:0]     key_reg [DEPTH];
    logic [KEY_BITS-1:0]     key_next [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_reg [DEPTH];
    logic [PAYLOAD_BITS-1:0] pay_next [DEPTH];
    logic [DEPTH-1:0]        le;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result registers
    logic                    done_reg;
    logic                    rvalid_reg;
    logic [KEY_BITS-1:0]     rkey_reg;
    logic [PAYLOAD_BITS-1:0] rpay_reg;
    logic [CNT_W-1:0]        rcount_reg;
    logic                    rempty_reg;
    status_t                 status_reg;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode;
            new_key_reg <= entry_key;
            new_pay_reg <= entry_payload;
        end
    end

    // Per-cell compare: occupied and key <= new key (thermometer code)
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
            le[i] = (CNT_W'(i) < count_reg) && (key_reg[i] <= new_key_reg);
    end

    // Cell next values
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_next[i] = key_reg[i];
            pay_next[i] = pay_reg[i];
        end
        if (cmd.do_insert)
        begin
            if (!le[0])
            begin
                key_next[0] = new_key_reg;
                pay_next[0] = new_pay_reg;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!le[i])
                begin
                    if (le[i-1])
                    begin
                        key_next[i] = new_key_reg;
                        pay_next[i] = new_pay_reg;
                    end
                    else
                    begin
                        key_next[i] = key_reg[i-1];
                        pay_next[i] = pay_reg[i-1];
                    end
                end
            end
        end
        else if (cmd.do_remove)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                key_next[i] = key_reg[i+1];
                pay_next[i] = pay_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            key_reg[i] <= key_next[i];
            pay_reg[i] <= pay_next[i];
        end
    end

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_insert)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.do_remove)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign dp_stat.op_remove = (op_reg == OP_REMOVE);
    assign dp_stat.full      = (count_reg == CNT_W'(DEPTH));
    assign dp_stat.empty     = (count_reg == '0);

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    // Result fields
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rvalid_reg <= cmd.do_remove;
            rkey_reg   <= cmd.do_remove ? key_reg[0] : '0;
            rpay_reg   <= cmd.do_remove ? pay_reg[0] : '0;
            rcount_reg <= count_next;
            rempty_reg <= (count_next == '0);
            status_reg <= cmd.result;
        end
    end

    assign done            = done_reg;
    assign removed_valid   = rvalid_reg;
    assign removed_key     = rkey_reg;
    assign removed_payload = rpay_reg;
    assign stored_count    = rcount_reg;
    assign is_empty        = rempty_reg;
    assign status          = status_reg;

endmodule

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending key order, stable among equal
// keys; insert and remove-least requests, one result per request.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Signals
//  --------  ----------------------  -----------------------------------------
//  request   start & !busy           opcode, entry_key, entry_payload
//  result    done (one-cycle strobe) removed_valid, removed_key,
//                                    removed_payload, stored_count,
//                                    is_empty, status
//
//  A request is a capture, then one compare-and-shift of all cells in
//  parallel; done rises in the cycle after the shift and busy falls in
//  that same cycle, so a new request can start then.
//  Reset clears the controller, occupancy and the result strobe; cell
//  contents are not reset. The receiver cannot stall: each result is
//  valid for the single cycle that done is high.
//
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int KEY_BITS     = KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
    localparam int CNT_W       = $clog2(DEPTH + 1)
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    opcode,
    input  wire logic [KEY_BITS-1:0]     entry_key,
    input  wire logic [PAYLOAD_BITS-1:0] entry_payload,
    output logic                         done,
    output logic                         removed_valid,
    output logic [KEY_BITS-1:0]          removed_key,
    output logic [PAYLOAD_BITS-1:0]      removed_payload,
    output logic [CNT_W-1:0]             stored_count,
    output logic                         is_empty,
    output logic [1:0]                   status
);

    spq_cmd_t  cmd;
    spq_stat_t dp_stat;

    // Sequencer
    spq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dp_stat (dp_stat),
        .cmd     (cmd)
    );

    // Cells and result registers
    spq_datapath #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .dp_stat         (dp_stat),
        .opcode          (opcode),
        .entry_key       (entry_key),
        .entry_payload   (entry_payload),
        .done            (done),
        .removed_valid   (removed_valid),
        .removed_key     (removed_key),
        .removed_payload (removed_payload),
        .stored_count    (stored_count),
        .is_empty        (is_empty),
        .status          (status)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue. It drives insert and
// remove requests with random gaps, tracks a shadow copy of the sorted cells
// and compares every result strobe field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import spq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QDEPTH     = DEPTH_DEF;
    localparam int KW         = KEY_BITS_DEF;
    localparam int PW         = PAYLOAD_BITS_DEF;
    localparam int CW         = $clog2(QDEPTH + 1);
    localparam int RAND_ITEMS = 900;
    localparam int CALM_TAIL  = 150;   // last requests get no random idle gaps
    localparam int STALL_MAX  = 400;   // cycles without any request or result

    // One expected result
    typedef struct {
        logic          rvalid;
        logic [KW-1:0] rkey;
        logic [PW-1:0] rpayload;
        logic [CW-1:0] count;
        logic          empty;
        status_t       stat;
    } pq_result_t;

    // Shadow of the queue contents plus the results still owed by the block
    class pq_shadow;
        logic [KW-1:0] key_cells[QDEPTH];
        logic [PW-1:0] payload_cells[QDEPTH];
        int            fill;
        pq_result_t    due_results[$];
        int            mismatches;
        int            n_insert, n_remove, n_full, n_empty, peak_fill;

        function new();
            fill       = 0;
            mismatches = 0;
            n_insert   = 0;
            n_remove   = 0;
            n_full     = 0;
            n_empty    = 0;
            peak_fill  = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Apply an accepted request and queue the result it owes
        function void note_request(logic op, logic [KW-1:0] key, logic [PW-1:0] payload);
            pq_result_t r;
            int         pos;
            r.rvalid   = 1'b0;
            r.rkey     = '0;
            r.rpayload = '0;
            r.stat     = STAT_OK;
            if (op == OP_INSERT) begin
                if (fill >= QDEPTH) begin
                    r.stat = STAT_FULL;
                    n_full++;
                end
                else begin
                    // new entry goes behind all keys <= it, keeping ties in arrival order
                    pos = 0;
                    while (pos < fill && key_cells[pos] <= key)
                        pos++;
                    for (int i = fill; i > pos; i--) begin
                        key_cells[i]     = key_cells[i-1];
                        payload_cells[i] = payload_cells[i-1];
                    end
                    key_cells[pos]     = key;
                    payload_cells[pos] = payload;
                    fill++;
                    n_insert++;
                    if (fill > peak_fill)
                        peak_fill = fill;
                end
            end
            else begin
                if (fill == 0) begin
                    r.stat = STAT_EMPTY;
                    n_empty++;
                end
                else begin
                    r.rvalid   = 1'b1;
                    r.rkey     = key_cells[0];
                    r.rpayload = payload_cells[0];
                    for (int i = 1; i < fill; i++) begin
                        key_cells[i-1]     = key_cells[i];
                        payload_cells[i-1] = payload_cells[i];
                    end
                    fill--;
                    n_remove++;
                end
            end
            r.count = CW'(fill);
            r.empty = (fill == 0);
            due_results.push_back(r);
        endfunction

        function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR %0t: %s expected 0x%0h got 0x%0h", $realtime, what, exp_v,
                         act_v);
        endfunction

        // Compare one result strobe against the oldest owed result
        function void check_result(logic rvalid, logic [KW-1:0] rkey, logic [PW-1:0] rpayload,
                                   logic [CW-1:0] count, logic empty, logic [1:0] stat);
            pq_result_t e;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR %0t: result strobe with no request outstanding", $realtime);
                return;
            end
            e = due_results.pop_front();
            if (rvalid !== e.rvalid)
                flag("removed_valid", 64'(e.rvalid), 64'(rvalid));
            if (rkey !== e.rkey)
                flag("removed_key", 64'(e.rkey), 64'(rkey));
            if (rpayload !== e.rpayload)
                flag("removed_payload", 64'(e.rpayload), 64'(rpayload));
            if (count !== e.count)
                flag("stored_count", 64'(e.count), 64'(count));
            if (empty !== e.empty)
                flag("is_empty", 64'(e.empty), 64'(empty));
            if (stat !== e.stat)
                flag("status", 64'(e.stat), 64'(stat));
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic          opcode;
    logic [KW-1:0] entry_key;
    logic [PW-1:0] entry_payload;
    logic          done;
    logic          removed_valid;
    logic [KW-1:0] removed_key;
    logic [PW-1:0] removed_payload;
    logic [CW-1:0] stored_count;
    logic          is_empty;
    logic [1:0]    status;

    pq_shadow      shadow;
    int            stall_cycles;

    sorted_priority_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .entry_key       (entry_key),
        .entry_payload   (entry_payload),
        .done            (done),
        .removed_valid   (removed_valid),
        .removed_key     (removed_key),
        .removed_payload (removed_payload),
        .stored_count    (stored_count),
        .is_empty        (is_empty),
        .status          (status)
    );

    // 125 MHz clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_result(removed_valid, removed_key, removed_payload,
                                stored_count, is_empty, status);
    end

    // Watchdog: give up when neither a request nor a result moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("Timeout: no progress for %0d cycles", STALL_MAX);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one request and hold it until the block takes it
    task automatic send_request(logic op, logic [KW-1:0] key, logic [PW-1:0] payload);
        start         <= 1'b1;
        opcode        <= op;
        entry_key     <= key;
        entry_payload <= payload;
        do
            @(posedge clk);
        while (busy);
        shadow.note_request(op, key, payload);
    endtask

    // Sender idles for a number of cycles with junk on the fields
    task automatic idle_for(int cycles);
        start         <= 1'b0;
        opcode        <= 1'($urandom);
        entry_key     <= $urandom;
        entry_payload <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    // Sender holds off until every owed result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (shadow.pending() != 0);
    endtask

    // Keys lean toward zero, all ones and values up to 7 so ties are common
    function automatic logic [KW-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return KW'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int insert_pct;
        int phase_left;
        bit calm;

        shadow        = new();
        stall_cycles  = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        opcode        = OP_INSERT;
        entry_key     = '0;
        entry_payload = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: remove from empty, ties, extreme keys and payloads, fill up, overflow
        send_request(OP_REMOVE, '1, '1);
        send_request(OP_INSERT, 32'd5, 32'd1);
        send_request(OP_INSERT, 32'd5, 32'd2);
        send_request(OP_INSERT, '0, '1);
        send_request(OP_INSERT, '1, '0);
        send_request(OP_INSERT, '1, '1);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, 32'h8000_0000, 32'h5555_5555);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send_request(OP_INSERT, 32'd5, 32'd3);
        for (int i = 0; i < 7; i++)
            send_request(OP_INSERT, pick_key(), $urandom);
        send_request(OP_INSERT, 32'd1, 32'hDEAD_BEEF);   // queue is full here
        for (int i = 0; i < 7; i++)
            send_request(OP_REMOVE, $urandom, $urandom);
        wait_drained();

        // Random: phases that lean toward filling, draining or churning
        phase_left = 0;
        insert_pct = 50;
        calm       = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 60);
                case ($urandom_range(0, 2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
                calm = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
            end
            phase_left--;
            if (n < RAND_ITEMS - CALM_TAIL && !calm && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 16));
            if ($urandom_range(0, 99) < insert_pct)
                send_request(OP_INSERT, pick_key(), $urandom);
            else
                send_request(OP_REMOVE, $urandom, $urandom);
        end

        // Let the last results land, then a short quiet tail
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Ran %0d inserts, %0d removes; refused %0d full, %0d empty.",
                 shadow.n_insert, shadow.n_remove, shadow.n_full, shadow.n_empty);
        $display("Queue peaked at %0d of %0d entries.", shadow.peak_fill, QDEPTH);
        if (shadow.mismatches + shadow.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
